### rtl/core/triangle_osc_bank_gain_mixer_macros.svh
// Assertion macros shared by the checker.
`ifndef TRIANGLE_OSC_BANK_GAIN_MIXER_MACROS_SVH
`define TRIANGLE_OSC_BANK_GAIN_MIXER_MACROS_SVH

// Checked outside reset only.
`define TOSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define TOSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/core/tosc_pkg.sv
`timescale 1ns / 1ps

package tosc_pkg;

    // item field widths
    localparam int IDX_W    = 3;
    localparam int MODE_W   = 2;
    localparam int GAIN_W   = 16;
    localparam int STEP_W   = 31;
    localparam int PHASE_W  = 32;
    localparam int SAMPLE_W = 17;
    localparam int LIN_W    = 2 * IDX_W;

    // stream word widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 24;

    // oscillator arithmetic
    localparam int SMP_W  = 14;          // scaled triangle, about +-6554
    localparam int TRIX_W = 17;          // biased triangle >> 15
    localparam int DIVP_W = TRIX_W + 16; // times reciprocal of 5
    localparam int DIV_SH = 18;
    localparam logic [15:0] DIV5_RECIP = 16'd52429;
    localparam logic [PHASE_W:0] TRI_K_LO = 33'd268517376;
    localparam logic [PHASE_W:0] TRI_K_HI = 33'd4563484672;
    localparam int SMP_OFS = 8192;

    // mixer arithmetic
    localparam int PROD_W  = SMP_W + GAIN_W + 1;
    localparam int ACC_W   = PROD_W + 3;
    localparam int Q_SH    = 15;
    localparam int OUT_Q_W = ACC_W + 1 - Q_SH;
    localparam int ROUND_HALF = 16384;
    localparam int SAT_HI = 65535;
    localparam int SAT_LO = -65536;

    typedef logic [IDX_W-1:0]  t_idx;
    typedef logic [MODE_W-1:0] t_mode;
    typedef logic [0:0]        t_cfg_idx;

    localparam t_mode MODE_TICK = 2'd0;
    localparam t_mode MODE_GAIN = 2'd1;
    localparam t_mode MODE_STEP = 2'd2;

    localparam t_cfg_idx CFG_RUN  = 1'b0;
    localparam t_cfg_idx CFG_MASK = 1'b1;

    // C4..C5 major scale at 44.1 kHz
    localparam logic [STEP_W-1:0] SCALE_STEPS [8] = '{
        31'd25480551, 31'd28600002, 31'd32103176, 31'd34012051,
        31'd38177487, 31'd42852281, 31'd48099738, 31'd50960128
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_ADV_WAIT,
        ST_MIX,
        ST_MIX_WAIT,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic start;
        logic wr_gain;
        logic wr_step;
        logic adv_issue;
        logic mix_issue;
        logic out_load;
        t_idx src;
        t_idx chn;
    } t_ctrl_cmd;

    typedef struct packed {
        logic adv_busy;
        logic mix_busy;
        logic out_free;
    } t_dp_status;

endpackage

### rtl/core/tosc_ram.sv
`timescale 1ns / 1ps

module tosc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                          i_clk,
    input  logic                                          i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_waddr,
    input  logic [WIDTH-1:0]                              i_wdata,
    input  logic                                          i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  i_raddr,
    output logic [WIDTH-1:0]                              o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/tosc_ctrl.sv
`timescale 1ns / 1ps

module tosc_ctrl #(
    parameter int SOURCES  = 8,
    parameter int CHANNELS = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    input  tosc_pkg::t_mode       i_mode,
    output logic                  o_s_tready,
    input  tosc_pkg::t_dp_status  i_status,
    output tosc_pkg::t_ctrl_cmd   o_cmd
);
    localparam tosc_pkg::t_idx SRC_LAST = tosc_pkg::IDX_W'(SOURCES - 1);
    localparam tosc_pkg::t_idx CHN_LAST = tosc_pkg::IDX_W'(CHANNELS - 1);
    localparam tosc_pkg::t_idx IDX_ONE  = tosc_pkg::IDX_W'(1);

    tosc_pkg::t_state r_state, n_state;
    tosc_pkg::t_idx   r_src, n_src;
    tosc_pkg::t_idx   r_chn, n_chn;
    logic             accept;

    assign accept = i_s_tvalid && (r_state == tosc_pkg::ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tosc_pkg::ST_IDLE;
            r_src   <= '0;
            r_chn   <= '0;
        end else begin
            r_state <= n_state;
            r_src   <= n_src;
            r_chn   <= n_chn;
        end
    end

    // next state and sequencing counters
    always_comb begin
        n_state = r_state;
        n_src   = r_src;
        n_chn   = r_chn;
        unique case (r_state)
            tosc_pkg::ST_IDLE: begin
                if (accept && (i_mode == tosc_pkg::MODE_TICK)) begin
                    n_state = tosc_pkg::ST_ADV;
                    n_src   = '0;
                end
            end
            tosc_pkg::ST_ADV: begin
                if (r_src == SRC_LAST) begin
                    n_state = tosc_pkg::ST_ADV_WAIT;
                end else begin
                    n_src = r_src + IDX_ONE;
                end
            end
            tosc_pkg::ST_ADV_WAIT: begin
                if (!i_status.adv_busy) begin
                    n_state = tosc_pkg::ST_MIX;
                    n_src   = '0;
                    n_chn   = '0;
                end
            end
            tosc_pkg::ST_MIX: begin
                if (r_src == SRC_LAST) begin
                    n_state = tosc_pkg::ST_MIX_WAIT;
                end else begin
                    n_src = r_src + IDX_ONE;
                end
            end
            tosc_pkg::ST_MIX_WAIT: begin
                if (!i_status.mix_busy) begin
                    n_state = tosc_pkg::ST_EMIT;
                end
            end
            tosc_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    if (r_chn == CHN_LAST) begin
                        n_state = tosc_pkg::ST_IDLE;
                    end else begin
                        n_state = tosc_pkg::ST_MIX;
                        n_chn   = r_chn + IDX_ONE;
                        n_src   = '0;
                    end
                end
            end
            default: begin
                n_state = tosc_pkg::ST_IDLE;
            end
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_cmd.src  = r_src;
        o_cmd.chn  = r_chn;
        o_s_tready = 1'b0;
        unique case (r_state)
            tosc_pkg::ST_IDLE: begin
                o_s_tready    = 1'b1;
                o_cmd.start   = accept && (i_mode == tosc_pkg::MODE_TICK);
                o_cmd.wr_gain = accept && (i_mode == tosc_pkg::MODE_GAIN);
                o_cmd.wr_step = accept && (i_mode == tosc_pkg::MODE_STEP);
            end
            tosc_pkg::ST_ADV: begin
                o_cmd.adv_issue = 1'b1;
            end
            tosc_pkg::ST_MIX: begin
                o_cmd.mix_issue = 1'b1;
            end
            tosc_pkg::ST_EMIT: begin
                o_cmd.out_load = i_status.out_free;
            end
            tosc_pkg::ST_ADV_WAIT, tosc_pkg::ST_MIX_WAIT: begin
                o_cmd.out_load = 1'b0;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

### rtl/core/tosc_dp.sv
`timescale 1ns / 1ps

module tosc_dp #(
    parameter int SOURCES  = 8,
    parameter int CHANNELS = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  tosc_pkg::t_ctrl_cmd                   i_cmd,
    output tosc_pkg::t_dp_status                  o_status,
    input  logic                                  i_cfg_we,
    input  tosc_pkg::t_cfg_idx                    i_cfg_index,
    input  logic [7:0]                            i_cfg_wdata,
    input  tosc_pkg::t_idx                        i_src,
    input  tosc_pkg::t_idx                        i_chn,
    input  logic [tosc_pkg::GAIN_W-1:0]           i_gain,
    input  logic [tosc_pkg::STEP_W-1:0]           i_step,
    input  logic                                  i_m_tready,
    output logic                                  o_m_tvalid,
    output tosc_pkg::t_idx                        o_chan,
    output logic signed [tosc_pkg::SAMPLE_W-1:0]  o_sample,
    output logic                                  o_last
);
    localparam int SRC_AW     = (SOURCES > 1) ? $clog2(SOURCES) : 1;
    localparam int GAIN_DEPTH = SOURCES * CHANNELS;
    localparam int GAIN_AW    = (GAIN_DEPTH > 1) ? $clog2(GAIN_DEPTH) : 1;
    localparam int PW  = tosc_pkg::PHASE_W;
    localparam int SW  = tosc_pkg::SMP_W;
    localparam int PRW = tosc_pkg::PROD_W;
    localparam int AW  = tosc_pkg::ACC_W;
    localparam int QW  = tosc_pkg::OUT_Q_W;
    localparam logic [tosc_pkg::IDX_W:0] SRC_CNT = (tosc_pkg::IDX_W + 1)'(SOURCES);
    localparam logic [tosc_pkg::IDX_W:0] CHN_CNT = (tosc_pkg::IDX_W + 1)'(CHANNELS);
    localparam logic [tosc_pkg::LIN_W-1:0] CHN_MUL = tosc_pkg::LIN_W'(CHANNELS);
    localparam tosc_pkg::t_idx CHN_LAST = tosc_pkg::IDX_W'(CHANNELS - 1);
    localparam logic signed [QW-1:0] SAT_HI = QW'(tosc_pkg::SAT_HI);
    localparam logic signed [QW-1:0] SAT_LO = QW'(tosc_pkg::SAT_LO);
    localparam logic [tosc_pkg::IDX_W-1:0] IDX_PAD = '0;

    // configuration and oscillator state
    logic                          r_run;
    logic [7:0]                    r_mask;
    logic [PW-1:0]                 r_phase [SOURCES];
    logic [tosc_pkg::STEP_W-1:0]   r_step  [SOURCES];
    logic signed [SW-1:0]          r_smp   [SOURCES];
    logic [GAIN_DEPTH-1:0]         r_gvld;

    // oscillator pipe
    logic                          r_a_vld, r_b_vld, r_c_vld;
    logic                          r_a_act, r_b_act, r_c_act;
    logic [SRC_AW-1:0]             r_a_src, r_b_src, r_c_src;
    logic [PW-1:0]                 r_a_p;
    logic [tosc_pkg::TRIX_W-1:0]   r_b_x;
    logic [tosc_pkg::DIVP_W-1:0]   r_c_prod;

    // mixer pipe
    logic                          r_m1_vld, r_m2_vld;
    logic                          r_m1_gv;
    logic [SRC_AW-1:0]             r_m1_src;
    logic signed [PRW-1:0]         r_prod;
    logic signed [AW-1:0]          r_acc;

    // result register
    logic                          r_out_vld;
    tosc_pkg::t_idx                r_out_chan;
    logic signed [tosc_pkg::SAMPLE_W-1:0] r_out_sample;
    logic                          r_out_last;

    logic [SRC_AW-1:0]             adv_sel;
    logic [SRC_AW-1:0]             wr_sel;
    logic                          adv_act;
    logic [PW-1:0]                 adv_sum;
    logic [PW:0]                   tri_u;
    logic [tosc_pkg::DIVP_W-tosc_pkg::DIV_SH-1:0] div_q;
    logic signed [SW+1:0]          smp_wide;
    logic                          src_ok, chn_ok;
    logic                          gain_we;
    logic [tosc_pkg::LIN_W-1:0]    waddr_lin, raddr_lin;
    logic [tosc_pkg::GAIN_W-1:0]   ram_rdata, gain_eff;
    logic signed [PRW-1:0]         mix_prod;
    logic signed [AW:0]            acc_rnd;
    logic signed [QW-1:0]          acc_q;
    logic signed [tosc_pkg::SAMPLE_W-1:0] sat_val;
    logic                          out_free;

    assign adv_sel = i_cmd.src[SRC_AW-1:0];
    assign wr_sel  = i_src[SRC_AW-1:0];
    assign adv_act = r_run & r_mask[i_cmd.src];
    assign adv_sum = r_phase[adv_sel] + {1'b0, r_step[adv_sel]};

    assign src_ok  = {1'b0, i_src} < SRC_CNT;
    assign chn_ok  = {1'b0, i_chn} < CHN_CNT;
    assign gain_we = i_cmd.wr_gain && src_ok && chn_ok;

    assign waddr_lin = {IDX_PAD, i_src} * CHN_MUL + {IDX_PAD, i_chn};
    assign raddr_lin = {IDX_PAD, i_cmd.src} * CHN_MUL + {IDX_PAD, i_cmd.chn};

    // fold: biased triangle, bias keeps the floor division unsigned
    assign tri_u = r_a_p[PW-1] ? (tosc_pkg::TRI_K_HI - {1'b0, r_a_p})
                               : ({1'b0, r_a_p} + tosc_pkg::TRI_K_LO);

    // divide by 5 through the reciprocal; exact for the 17-bit range
    assign div_q    = r_c_prod[tosc_pkg::DIVP_W-1:tosc_pkg::DIV_SH];
    assign smp_wide = $signed({1'b0, div_q}) - (SW + 2)'(tosc_pkg::SMP_OFS);

    assign gain_eff = r_m1_gv ? ram_rdata : '0;
    assign mix_prod = r_smp[r_m1_src] * $signed({1'b0, gain_eff});

    assign acc_rnd = {r_acc[AW-1], r_acc} + (AW + 1)'(tosc_pkg::ROUND_HALF);
    assign acc_q   = acc_rnd[AW:tosc_pkg::Q_SH];

    always_comb begin
        if (acc_q > SAT_HI) begin
            sat_val = SAT_HI[tosc_pkg::SAMPLE_W-1:0];
        end else if (acc_q < SAT_LO) begin
            sat_val = SAT_LO[tosc_pkg::SAMPLE_W-1:0];
        end else begin
            sat_val = acc_q[tosc_pkg::SAMPLE_W-1:0];
        end
    end

    assign out_free = !r_out_vld || i_m_tready;

    tosc_ram #(
        .WIDTH (tosc_pkg::GAIN_W),
        .DEPTH (GAIN_DEPTH)
    ) u_gain_ram (
        .i_clk   (i_clk),
        .i_we    (gain_we),
        .i_waddr (waddr_lin[GAIN_AW-1:0]),
        .i_wdata (i_gain),
        .i_re    (i_cmd.mix_issue),
        .i_raddr (raddr_lin[GAIN_AW-1:0]),
        .o_rdata (ram_rdata)
    );

    // valid bits, config, gain flags, phases, steps and accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_mask    <= 8'hFF;
            r_gvld    <= '0;
            r_a_vld   <= 1'b0;
            r_b_vld   <= 1'b0;
            r_c_vld   <= 1'b0;
            r_m1_vld  <= 1'b0;
            r_m2_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_acc     <= '0;
            for (int s = 0; s < SOURCES; s++) begin
                r_phase[s] <= '0;
                r_step[s]  <= tosc_pkg::SCALE_STEPS[s];
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    tosc_pkg::CFG_RUN:  r_run  <= i_cfg_wdata[0];
                    tosc_pkg::CFG_MASK: r_mask <= i_cfg_wdata;
                    default: r_run <= r_run;
                endcase
            end
            if (gain_we) begin
                r_gvld[waddr_lin[GAIN_AW-1:0]] <= 1'b1;
            end
            if (i_cmd.wr_step && src_ok) begin
                r_step[wr_sel] <= i_step;
            end
            if (i_cmd.adv_issue && adv_act) begin
                r_phase[adv_sel] <= adv_sum;
            end
            r_a_vld  <= i_cmd.adv_issue;
            r_b_vld  <= r_a_vld;
            r_c_vld  <= r_b_vld;
            r_m1_vld <= i_cmd.mix_issue;
            r_m2_vld <= r_m1_vld;

            if (i_cmd.start || i_cmd.out_load) begin
                r_acc <= '0;
            end else if (r_m2_vld) begin
                r_acc <= r_acc + {{(AW - PRW){r_prod[PRW-1]}}, r_prod};
            end

            if (i_cmd.out_load) begin
                r_out_vld <= 1'b1;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_a_p    <= adv_sum;
        r_a_act  <= adv_act;
        r_a_src  <= adv_sel;
        r_b_x    <= tri_u[PW-1:tosc_pkg::Q_SH];
        r_b_act  <= r_a_act;
        r_b_src  <= r_a_src;
        r_c_prod <= r_b_x * tosc_pkg::DIV5_RECIP;
        r_c_act  <= r_b_act;
        r_c_src  <= r_b_src;
        if (r_c_vld) begin
            r_smp[r_c_src] <= r_c_act ? smp_wide[SW-1:0] : '0;
        end
        r_m1_src <= adv_sel;
        r_m1_gv  <= r_gvld[raddr_lin[GAIN_AW-1:0]];
        r_prod   <= mix_prod;
        if (i_cmd.out_load) begin
            r_out_chan   <= i_cmd.chn;
            r_out_sample <= sat_val;
            r_out_last   <= (i_cmd.chn == CHN_LAST);
        end
    end

    assign o_status.adv_busy = r_a_vld | r_b_vld | r_c_vld;
    assign o_status.mix_busy = r_m1_vld | r_m2_vld;
    assign o_status.out_free = out_free;

    assign o_m_tvalid = r_out_vld;
    assign o_chan     = r_out_chan;
    assign o_sample   = r_out_sample;
    assign o_last     = r_out_last;

endmodule

### rtl/core/triangle_osc_bank_gain_mixer.sv
`timescale 1ns / 1ps
// Bank of SOURCES triangle oscillators mixed into CHANNELS outputs through a
// Q1.15 source-by-channel gain table. Requests on the slave stream carry a
// mode: a tick advances every enabled oscillator by its phase step, folds the
// phase to a triangle scaled by 0.2, and emits one saturated Q2.15 sample per
// channel (channel 0 first, tlast on the final one); mode 1 writes one gain
// entry, mode 2 writes one phase step; mode 3 and out-of-range indexes are
// dropped. With run_enable low a tick emits zeros and phases hold. Gains read
// zero until written (per-entry valid bits, no clearing pass); phase steps
// come out of reset on the C4..C5 major scale at 44.1 kHz. A tick first
// advances the oscillators and then mixes the channels in turn: one shared
// multiplier walks the gain table one entry per cycle within a channel,
// waiting between channels while the output register is stalled, and the
// oscillator fold runs through the a, b and c pipe registers. A new request
// is taken once the last channel has been handed to the output register.

module triangle_osc_bank_gain_mixer #(
    parameter int SOURCES  = 8,
    parameter int CHANNELS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // slave stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [1:0] mode, [4:2] source_index, [7:5] channel_index,
    // [23:8] gain_value, [54:24] step_value, [55] zero
    input  logic [tosc_pkg::S_TDATA_W-1:0]    i_s_tdata,
    // master stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [2:0] channel_number, [19:3] channel_sample, [23:20] zero
    output logic [tosc_pkg::M_TDATA_W-1:0]    o_m_tdata,
    output logic                              o_m_tlast,
    // config write port: 0 run_enable, 1 osc_enable_mask
    input  logic                              i_cfg_we,
    input  tosc_pkg::t_cfg_idx                i_cfg_index,
    input  logic [7:0]                        i_cfg_wdata
);
    tosc_pkg::t_ctrl_cmd   cmd;
    tosc_pkg::t_dp_status  status;
    tosc_pkg::t_idx        out_chan;
    logic signed [tosc_pkg::SAMPLE_W-1:0] out_sample;

    tosc_ctrl #(
        .SOURCES  (SOURCES),
        .CHANNELS (CHANNELS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_mode     (i_s_tdata[1:0]),
        .o_s_tready (o_s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tosc_dp #(
        .SOURCES  (SOURCES),
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_src       (i_s_tdata[4:2]),
        .i_chn       (i_s_tdata[7:5]),
        .i_gain      (i_s_tdata[23:8]),
        .i_step      (i_s_tdata[54:24]),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_chan      (out_chan),
        .o_sample    (out_sample),
        .o_last      (o_m_tlast)
    );

    assign o_m_tdata = {4'b0000, out_sample, out_chan};

endmodule

### rtl/core/tosc_chk.sv
`timescale 1ns / 1ps
`include "triangle_osc_bank_gain_mixer_macros.svh"

module tosc_chk #(
    parameter int CHANNELS = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            o_s_tready,
    input  logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    input  logic [tosc_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input  logic                            o_m_tlast
);
    localparam tosc_pkg::t_idx CHN_LAST = tosc_pkg::IDX_W'(CHANNELS - 1);

    `TOSC_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "stalled result changed")

    `TOSC_ASSERT_ALWAYS(a_rst_quiet, i_clk, !i_rst_n |=> !o_m_tvalid, "result shown right after reset")

    `TOSC_ASSERT(a_last_chan, i_clk, i_rst_n, o_m_tvalid |-> (o_m_tlast == (o_m_tdata[2:0] == CHN_LAST)), "tlast not on final channel")

    // mid-frame the block must not take a new request
    `TOSC_ASSERT(a_busy_mid, i_clk, i_rst_n, o_m_tvalid && i_m_tready && !o_m_tlast |-> !o_s_tready, "request taken mid frame")

endmodule

bind triangle_osc_bank_gain_mixer tosc_chk #(
    .CHANNELS (CHANNELS)
) u_tosc_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

### bench/triangle_osc_bank_gain_mixer_tb.sv
`timescale 1ns / 1ps

module triangle_osc_bank_gain_mixer_tb;
    import tosc_pkg::*;

    localparam int NSRC = 8;
    localparam int NCHN = 8;
    // long enough for a tick at 8 x 8; leave room for a write still in flight
    localparam int SETTLE_CYCLES = 150;
    localparam t_mode MODE_UNUSED = 2'd3;
    localparam logic [30:0] STEP_MAX = 31'h7FFF_FFFF;
    localparam logic [15:0] GAIN_MAX = 16'hFFFF;

    typedef struct {
        logic [2:0]         chn;
        logic signed [16:0] smp;
        logic               last;
    } mix_result_t;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_s_tvalid = 1'b0;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata = '0;
    logic                 o_m_tvalid;
    logic                 i_m_tready = 1'b0;
    logic [M_TDATA_W-1:0] o_m_tdata;
    logic                 o_m_tlast;
    logic                 i_cfg_we = 1'b0;
    t_cfg_idx             i_cfg_index = CFG_RUN;
    logic [7:0]           i_cfg_wdata = '0;

    triangle_osc_bank_gain_mixer #(
        .SOURCES  (NSRC),
        .CHANNELS (NCHN)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    // Shadow copy of the oscillator bank and mixer
    logic [31:0] osc_phase [NSRC];
    logic [30:0] osc_step  [NSRC];
    logic [15:0] gain_tab  [NSRC][NCHN];
    logic        run_on;
    logic [7:0]  osc_mask;

    mix_result_t pending_mix[$];
    int          err_count = 0;
    int          src_gap_max = 0;
    int          sink_gap_max = 0;
    int          sink_wait = 0;
    bit          result_taken = 1'b0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch: %s got %0d want %0d", $realtime, what, got, want);
        err_count++;
    endtask

    // Triangle fold of the Q2.30 phase, scaled by 0.2 into Q1.15, ties rounded up
    function automatic longint tri_scaled(input logic [31:0] p);
        longint t;
        if (!p[31]) begin
            t = longint'(p) - 64'sd1073741824;
        end else begin
            t = 64'sd3221225472 - longint'(p);
        end
        return (t + 64'sd81920 + 64'sd1342177280) / 64'sd163840 - 64'sd8192;
    endfunction

    function automatic void predict_tick();
        longint      smp [NSRC];
        longint      acc;
        longint      v;
        mix_result_t r;
        for (int s = 0; s < NSRC; s++) begin
            smp[s] = 0;
            if (run_on && osc_mask[s]) begin
                osc_phase[s] = osc_phase[s] + {1'b0, osc_step[s]};
                smp[s] = tri_scaled(osc_phase[s]);
            end
        end
        for (int c = 0; c < NCHN; c++) begin
            acc = 0;
            for (int s = 0; s < NSRC; s++) begin
                acc += smp[s] * longint'(gain_tab[s][c]);
            end
            v = ((acc + 64'sd16384 + (64'sd1 <<< 40)) >>> 15) - (64'sd1 <<< 25);
            if (v > SAT_HI) v = SAT_HI;
            if (v < SAT_LO) v = SAT_LO;
            r.chn  = 3'(c);
            r.smp  = 17'(v);
            r.last = (c == NCHN - 1);
            pending_mix.push_back(r);
        end
    endfunction

    function automatic void apply_request(input t_mode mode, input t_idx src, input t_idx chn,
                                          input logic [15:0] gain, input logic [30:0] step);
        case (mode)
            MODE_TICK: predict_tick();
            MODE_GAIN: gain_tab[src][chn] = gain;
            MODE_STEP: osc_step[src] = step;
            default: ;  // unused mode, dropped
        endcase
    endfunction

    // One request on the slave stream; the shadow model is updated at acceptance
    task automatic send_request(input t_mode mode, input t_idx src, input t_idx chn,
                                input logic [15:0] gain, input logic [30:0] step);
        int gap;
        gap = (src_gap_max > 0) ? $urandom_range(0, src_gap_max) : 0;
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {1'b0, step, gain, chn, src, mode};
        do @(posedge i_clk); while (!o_s_tready);
        apply_request(mode, src, chn, gain, step);
    endtask

    // Drop valid, wait for every pending sample, then let the block settle
    task automatic drain_bench();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (pending_mix.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input t_cfg_idx idx, input logic [7:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_RUN) run_on = value[0];
        else osc_mask = value;
    endtask

    // Output side: stall a random count after each accepted sample
    always @(negedge i_clk) begin
        if (result_taken) begin
            sink_wait = (sink_gap_max > 0) ? $urandom_range(0, sink_gap_max) : 0;
            result_taken = 1'b0;
        end
        if (sink_wait > 0) begin
            i_m_tready <= 1'b0;
            sink_wait--;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic check_result(input logic [M_TDATA_W-1:0] data, input logic last);
        mix_result_t        want;
        logic signed [16:0] got_smp;
        got_smp = data[19:3];
        if (pending_mix.size() == 0) begin
            report_mismatch("sample with none pending, channel", int'(data[2:0]), -1);
        end else begin
            want = pending_mix.pop_front();
            if (data[2:0] !== want.chn)
                report_mismatch("channel_number", int'(data[2:0]), int'(want.chn));
            if (got_smp !== want.smp)
                report_mismatch("channel_sample", int'(got_smp), int'(want.smp));
            if (last !== want.last)
                report_mismatch("last", int'(last), int'(want.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            result_taken = 1'b1;
            check_result(o_m_tdata, o_m_tlast);
        end
    end

    // Reset state: run is off, so a tick is silent; mode 3 is dropped
    task automatic test_reset_state();
        send_request(MODE_TICK, 3'd7, 3'd7, GAIN_MAX, STEP_MAX);
        send_request(MODE_UNUSED, 3'd5, 3'd2, 16'h8000, 31'h5555_5555);
        drain_bench();
    endtask

    // Six sources at full-scale gain into channel 0 drive both saturation limits
    task automatic test_saturation();
        write_cfg(CFG_RUN, 8'd1);
        for (int s = 0; s < 6; s++) send_request(MODE_STEP, 3'(s), 3'd0, 16'd0, 31'd0);
        for (int s = 0; s < 6; s++) send_request(MODE_GAIN, 3'(s), 3'd0, GAIN_MAX, 31'd0);
        // phase held at 0: each of the six samples at the negative peak
        send_request(MODE_TICK, 3'd0, 3'd0, 16'd0, 31'd0);
        for (int s = 0; s < 6; s++) send_request(MODE_STEP, 3'(s), 3'd0, 16'd0, STEP_MAX);
        // phase just below the fold: each of the six samples at the positive peak
        send_request(MODE_TICK, 3'd0, 3'd0, 16'd0, 31'd0);
        drain_bench();
    endtask

    // All oscillators masked off: silent tick, phases hold
    task automatic test_mask_off();
        write_cfg(CFG_MASK, 8'h00);
        send_request(MODE_TICK, 3'd1, 3'd6, 16'h0001, 31'd1);
        drain_bench();
        write_cfg(CFG_MASK, 8'hFF);
        send_request(MODE_TICK, 3'd0, 3'd0, 16'd0, 31'd0);
        drain_bench();
    endtask

    task automatic random_phase(input int n_items, input logic run, input logic [7:0] mask,
                                input int sgap, input int kgap);
        int          pick;
        t_mode       mode;
        logic [15:0] gain;
        logic [30:0] step;
        write_cfg(CFG_RUN, {7'd0, run});
        write_cfg(CFG_MASK, mask);
        src_gap_max  = sgap;
        sink_gap_max = kgap;
        for (int n = 0; n < n_items; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 40) mode = MODE_TICK;
            else if (pick < 72) mode = MODE_GAIN;
            else if (pick < 95) mode = MODE_STEP;
            else mode = MODE_UNUSED;
            gain = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 32768));
            step = ($urandom_range(0, 1) == 0) ? 31'($urandom)
                                               : 31'($urandom_range(0, 60000000));
            send_request(mode, 3'($urandom), 3'($urandom), gain, step);
        end
        drain_bench();
    endtask

    task automatic test_random();
        random_phase(30, 1'b1, 8'hFF, 0, 0);
        random_phase(30, 1'b1, 8'($urandom), 19, 19);
        random_phase(20, 1'b0, 8'($urandom), 19, 0);
        random_phase(20, 1'b1, 8'h01, 0, 19);
        random_phase(20, 1'b1, 8'h80, 19, 19);
        random_phase(30, 1'b1, 8'hFF, 19, 19);
    endtask

    initial begin
        run_on   = 1'b0;
        osc_mask = 8'hFF;
        for (int s = 0; s < NSRC; s++) begin
            osc_phase[s] = '0;
            osc_step[s]  = SCALE_STEPS[s];
            for (int c = 0; c < NCHN; c++) gain_tab[s][c] = '0;
        end
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        test_reset_state();
        test_saturation();
        test_mask_off();
        test_random();

        if (err_count == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
